@@ design/png_tiff_row_unfilter_top_assert.svh @@
// ----------------------------------------------------------------------------
// Row unfilter assertion macros
// Clocked assertion helpers shared by the row unfilter modules.
// ----------------------------------------------------------------------------
`ifndef PNG_TIFF_ROW_UNFILTER_TOP_ASSERT_SVH
`define PNG_TIFF_ROW_UNFILTER_TOP_ASSERT_SVH

// The property is checked on every rising clk_i edge outside of reset.
`define PTRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true on a rising clk_i edge outside of reset.
`define PTRU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ design/ptru_pkg.sv @@
// ----------------------------------------------------------------------------
// Row unfilter package
// Types, register codes, filter codes and the Paeth predictor function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptru_pkg;

  localparam int unsigned POS_W      = 13;
  localparam int unsigned BPP_W      = 4;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [BPP_W-1:0]  bpp_t;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BPP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW  = 2'd2;

  localparam logic MODE_PNG  = 1'b0;
  localparam logic MODE_TIFF = 1'b1;

  localparam logic [7:0] FILTER_CODE_MAX   = 8'd4;
  localparam logic [7:0] FILTER_ALIAS_BASE = 8'd10;
  localparam logic [7:0] FILTER_ALIAS_MAX  = 8'd14;

  typedef enum logic [2:0] {
    FILT_NONE,
    FILT_SUB,
    FILT_UP,
    FILT_AVG,
    FILT_PAETH
  } filter_e;

  typedef struct packed {
    logic mode;
    bpp_t bpp;
    pos_t rb;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    pos_t       pos;
    slot_t      slot;
    logic       has_left;
    filter_e    filter;
    logic       png;
    logic       last;
    logic       bad;
  } item_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [9:0] ab;
    logic [9:0] cc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    ab = {2'b00, a} + {2'b00, b};
    cc = {1'b0, c, 1'b0};
    pa = (b > c) ? {2'b00, b - c} : {2'b00, c - b};
    pb = (a > c) ? {2'b00, a - c} : {2'b00, c - a};
    pc = (ab > cc) ? (ab - cc) : (cc - ab);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

endpackage

@@ design/ptru_slot_rem.sv @@
// ----------------------------------------------------------------------------
// Row unfilter pixel slot remainder unit
// Bit-serial restoring remainder of the row position by the pixel size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptru_slot_rem (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ptru_pkg::pos_t  pos_i,
  input  ptru_pkg::bpp_t  div_i,
  output logic            busy_o,
  output logic            done_o,
  output ptru_pkg::slot_t rem_o
);

  localparam logic [3:0] STEPS = 4'(ptru_pkg::POS_W);

  logic [3:0] cnt_q, cnt_d;
  logic [3:0] rem_q, rem_d;
  logic [3:0] idx;
  logic [4:0] shifted;
  logic [4:0] trial;

  always_comb begin
    idx     = cnt_q - 4'd1;
    shifted = {rem_q, pos_i[idx]};
    trial   = (shifted >= {1'b0, div_i}) ? (shifted - {1'b0, div_i}) : shifted;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    if (start_i) begin
      cnt_d = STEPS;
      rem_d = '0;
    end else if (cnt_q != 4'd0) begin
      cnt_d = cnt_q - 4'd1;
      rem_d = trial[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rem_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != 4'd0);
  assign done_o = (cnt_q == 4'd1) && !start_i;
  assign rem_o  = ptru_pkg::slot_t'(trial[3:0]);

endmodule

@@ design/ptru_ctrl.sv @@
// ----------------------------------------------------------------------------
// Row unfilter input control
// Row position, filter decode, dropped rows and pixel slot tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "png_tiff_row_unfilter_top_assert.svh"

module ptru_ctrl #(
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptru_pkg::cfg_t    cfg_i,
  input  logic              cfg_we_i,
  input  logic              in_valid_i,
  input  logic [7:0]        in_data_i,
  output logic              in_ready_o,
  input  logic              s1_ready_i,
  output logic              issue_valid_o,
  output ptru_pkg::item_t   issue_o
);

  localparam int unsigned SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  ptru_pkg::pos_t    col_q, col_d;
  logic [SW-1:0]     slot_q, slot_d;
  ptru_pkg::filter_e filter_q, filter_d;
  logic              drop_q, drop_d;

  logic              accept;
  ptru_pkg::pos_t    pos_data;
  ptru_pkg::pos_t    pos_next;
  logic              last;
  ptru_pkg::pos_t    col_next;
  logic [ptru_pkg::SLOT_W:0] slot_inc;
  logic [SW-1:0]     slot_next;
  logic              code_ok;
  logic [7:0]        code_fold;
  logic              rem_busy;
  logic              rem_done;
  ptru_pkg::slot_t   rem_val;

  ptru_slot_rem u_slot_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we_i),
    .pos_i   (pos_next),
    .div_i   (cfg_i.bpp),
    .busy_o  (rem_busy),
    .done_o  (rem_done),
    .rem_o   (rem_val)
  );

  assign in_ready_o = s1_ready_i && !rem_busy && !cfg_we_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pos_data  = (cfg_i.mode == ptru_pkg::MODE_TIFF) ? col_q : (col_q - 13'd1);
    if (cfg_i.mode == ptru_pkg::MODE_TIFF) begin
      pos_next = col_q;
    end else begin
      pos_next = (col_q == '0) ? '0 : (col_q - 13'd1);
    end
    last      = (({1'b0, pos_data} + 14'd1) >= {1'b0, cfg_i.rb});
    col_next  = last ? '0 : (col_q + 13'd1);
    slot_inc  = {1'b0, ptru_pkg::slot_t'(slot_q)} + 5'd1;
    slot_next = (last || (slot_inc >= {1'b0, cfg_i.bpp})) ? '0 : SW'(slot_inc);
    code_ok   = (in_data_i <= ptru_pkg::FILTER_CODE_MAX) ||
                ((in_data_i >= ptru_pkg::FILTER_ALIAS_BASE) &&
                 (in_data_i <= ptru_pkg::FILTER_ALIAS_MAX));
    code_fold = (in_data_i >= ptru_pkg::FILTER_ALIAS_BASE) ?
                (in_data_i - ptru_pkg::FILTER_ALIAS_BASE) : in_data_i;
  end

  always_comb begin
    col_d             = col_q;
    slot_d            = slot_q;
    filter_d          = filter_q;
    drop_d            = drop_q;
    issue_valid_o     = 1'b0;
    issue_o.data      = in_data_i;
    issue_o.pos       = pos_data;
    issue_o.slot      = ptru_pkg::slot_t'(slot_q);
    issue_o.has_left  = (pos_data >= 13'(cfg_i.bpp));
    issue_o.filter    = filter_q;
    issue_o.png       = 1'b1;
    issue_o.last      = last;
    issue_o.bad       = 1'b0;
    if (accept) begin
      if (cfg_i.mode == ptru_pkg::MODE_TIFF) begin
        issue_valid_o  = 1'b1;
        issue_o.filter = ptru_pkg::FILT_SUB;
        issue_o.png    = 1'b0;
        col_d          = col_next;
        slot_d         = slot_next;
      end else if (col_q == '0) begin
        col_d  = 13'd1;
        slot_d = '0;
        if (code_ok) begin
          filter_d = ptru_pkg::filter_e'(code_fold[2:0]);
          drop_d   = 1'b0;
        end else begin
          filter_d      = ptru_pkg::FILT_NONE;
          drop_d        = 1'b1;
          issue_valid_o = 1'b1;
          issue_o.bad   = 1'b1;
          issue_o.last  = 1'b0;
        end
      end else begin
        col_d  = col_next;
        slot_d = slot_next;
        if (drop_q) begin
          if (last) begin
            drop_d = 1'b0;
          end
        end else begin
          issue_valid_o = 1'b1;
        end
      end
    end
    if (rem_done) begin
      slot_d = SW'(rem_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      slot_q   <= '0;
      filter_q <= ptru_pkg::FILT_NONE;
      drop_q   <= 1'b0;
    end else begin
      col_q    <= col_d;
      slot_q   <= slot_d;
      filter_q <= filter_d;
      drop_q   <= drop_d;
    end
  end

  `PTRU_ASSERT(a_slot_below_bpp, !rem_busy |-> ptru_pkg::slot_t'(slot_q) < cfg_i.bpp, "pixel slot out of range")
  `PTRU_ASSERT(a_filter_byte_step, accept && cfg_i.mode == ptru_pkg::MODE_PNG && col_q == '0 |=> col_q == 13'd1, "filter byte did not open the row")
  `PTRU_ASSERT(a_row_end_slot, issue_valid_o && issue_o.last |=> slot_q == '0, "slot not cleared at row end")

endmodule

@@ design/ptru_recon.sv @@
// ----------------------------------------------------------------------------
// Row unfilter reconstruction stage
// Prior row memory, pixel histories, predictor and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "png_tiff_row_unfilter_top_assert.svh"

module ptru_recon #(
  parameter int unsigned MAX_ROW_BYTES   = 4096,
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            issue_valid_i,
  input  ptru_pkg::item_t issue_i,
  output logic            s1_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      pixel_byte_o,
  output logic            row_end_o,
  output logic            bad_filter_o
);

  localparam int unsigned AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int unsigned SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ROW_BYTES - 1);

  logic [7:0]      mem_q [MAX_ROW_BYTES];
  logic [7:0]      rdata_q;
  logic            clr_busy_q;
  logic [AW-1:0]   clr_addr_q;

  logic [7:0]      left_q [MAX_PIXEL_BYTES];
  logic [7:0]      upleft_q [MAX_PIXEL_BYTES];

  logic            s1_valid_q;
  ptru_pkg::item_t s1_q;

  logic            out_valid_q;
  logic [7:0]      pixel_q;
  logic            row_end_q;
  logic            bad_q;

  logic            fire;
  logic [SW-1:0]   slot;
  logic [7:0]      a, b, c, pred, r;
  logic [8:0]      avg_sum;
  logic            mem_we, mem_re;
  logic [AW-1:0]   waddr, raddr;

  assign fire       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_ready_o = !clr_busy_q && (!s1_valid_q || fire);

  always_comb begin
    slot    = s1_q.slot[SW-1:0];
    a       = s1_q.has_left ? left_q[slot] : 8'd0;
    c       = s1_q.has_left ? upleft_q[slot] : 8'd0;
    b       = s1_q.png ? rdata_q : 8'd0;
    avg_sum = {1'b0, a} + {1'b0, b};
    case (s1_q.filter)
      ptru_pkg::FILT_SUB:   pred = a;
      ptru_pkg::FILT_UP:    pred = b;
      ptru_pkg::FILT_AVG:   pred = avg_sum[8:1];
      ptru_pkg::FILT_PAETH: pred = ptru_pkg::paeth(a, b, c);
      default:              pred = 8'd0;
    endcase
    r      = s1_q.data + pred;
    mem_we = fire && !s1_q.bad && s1_q.png;
    mem_re = issue_valid_i && s1_ready_o && issue_i.png && !issue_i.bad;
    waddr  = AW'(s1_q.pos);
    raddr  = AW'(issue_i.pos);
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= 8'd0;
    end else if (mem_we) begin
      mem_q[waddr] <= r;
    end
    if (mem_re) begin
      rdata_q <= (mem_we && (waddr == raddr)) ? r : mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == LAST_ADDR) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_PIXEL_BYTES); i++) begin
        left_q[i]   <= 8'd0;
        upleft_q[i] <= 8'd0;
      end
    end else if (fire && !s1_q.bad) begin
      left_q[slot] <= r;
      if (s1_q.png) begin
        upleft_q[slot] <= b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      s1_valid_q <= issue_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready_o && issue_valid_i) begin
      s1_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pixel_q   <= s1_q.bad ? 8'd0 : r;
      row_end_q <= s1_q.bad ? 1'b0 : s1_q.last;
      bad_q     <= s1_q.bad;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = pixel_q;
  assign row_end_o    = row_end_q;
  assign bad_filter_o = bad_q;

  `PTRU_ASSERT_NEVER(a_issue_in_clear, clr_busy_q && issue_valid_i, "item issued during prior row clear")
  `PTRU_ASSERT(a_bad_zero, out_valid_o && bad_filter_o |-> pixel_byte_o == 8'd0 && !row_end_o, "error result carries data")
  `PTRU_ASSERT(a_s1_hold, s1_valid_q && !fire |=> s1_valid_q && $stable(s1_q.pos), "stalled item lost")

endmodule

@@ design/png_tiff_row_unfilter_top.sv @@
// ----------------------------------------------------------------------------
// PNG and TIFF row unfilter
// Undoes PNG per-row filters or the TIFF horizontal predictor, one byte per
// transfer, with the prior row kept in an on-chip memory.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake                  Payload
//   input    in         in_valid_i / in_ready_o    data_byte_i
//   output   out        out_valid_o / out_ready_i  pixel_byte_o, row_end_o, bad_filter_o
//   config   in         cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// One byte is accepted per cycle unless input is held off as below; each byte is
// registered in the reconstruction stage with its prior row memory read, then
// in the output register. After reset the prior row memory is cleared, with no
// input transfer until it is done. Each register write holds off input while
// the bit-serial remainder unit re-derives the pixel slot. A stalled output
// stops input only once the reconstruction stage is also full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module png_tiff_row_unfilter_top #(
  parameter int unsigned MAX_ROW_BYTES   = 4096,
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        data_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [7:0]                        pixel_byte_o,
  output logic                              row_end_o,
  output logic                              bad_filter_o,
  input  logic                              cfg_we_i,
  input  logic [ptru_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ptru_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam ptru_pkg::bpp_t BPP_MAX =
    ptru_pkg::bpp_t'((MAX_PIXEL_BYTES > 15) ? 15 : MAX_PIXEL_BYTES);
  localparam ptru_pkg::pos_t RB_MAX =
    ptru_pkg::pos_t'((MAX_ROW_BYTES > 8191) ? 8191 : MAX_ROW_BYTES);

  logic            mode_q;
  ptru_pkg::bpp_t  bpp_q;
  ptru_pkg::pos_t  row_q;
  ptru_pkg::cfg_t  cfg;
  logic            s1_ready;
  logic            issue_valid;
  ptru_pkg::item_t issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ptru_pkg::MODE_PNG;
      bpp_q  <= 4'd1;
      row_q  <= 13'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ptru_pkg::REG_MODE: mode_q <= cfg_wdata_i[0];
        ptru_pkg::REG_BPP:  bpp_q  <= cfg_wdata_i[3:0];
        ptru_pkg::REG_ROW:  row_q  <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mode = mode_q;
    if (bpp_q == '0) begin
      cfg.bpp = 4'd1;
    end else begin
      cfg.bpp = (bpp_q > BPP_MAX) ? BPP_MAX : bpp_q;
    end
    if (row_q == '0) begin
      cfg.rb = 13'd1;
    end else begin
      cfg.rb = (row_q > RB_MAX) ? RB_MAX : row_q;
    end
  end

  ptru_ctrl #(
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cfg_we_i      (cfg_we_i),
    .in_valid_i    (in_valid_i),
    .in_data_i     (data_byte_i),
    .in_ready_o    (in_ready_o),
    .s1_ready_i    (s1_ready),
    .issue_valid_o (issue_valid),
    .issue_o       (issue)
  );

  ptru_recon #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_recon (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_valid_i (issue_valid),
    .issue_i       (issue),
    .s1_ready_o    (s1_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_byte_o  (pixel_byte_o),
    .row_end_o     (row_end_o),
    .bad_filter_o  (bad_filter_o)
  );

endmodule

@@ sim/png_tiff_row_unfilter_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row unfilter testbench
// Streams PNG rows (filter byte plus data bytes) and TIFF predictor rows into
// the unfilter under random input gaps and output stalls. A scoreboard keeps
// its own prior row, left and upper-left history and row position, rebuilds
// every byte as it is accepted, and checks each output transfer in order.
// Register settings change between phases, often mid-row, and cover the
// clamped extremes of the pixel size and row length.
// ----------------------------------------------------------------------------

module png_tiff_row_unfilter_top_tb;

  localparam int MAX_ROW       = 4096;
  localparam int MAX_PIX       = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 150;

  typedef logic [ptru_pkg::CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [ptru_pkg::CFG_IDX_W-1:0]  cfg_idx_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       bad;
  } pixel_out_t;

  class unfilter_scoreboard;
    logic              mode;
    ptru_pkg::bpp_t    bpp_reg;
    ptru_pkg::pos_t    row_reg;
    logic [7:0]        prior_line [MAX_ROW];
    logic [7:0]        left_px [MAX_PIX];
    logic [7:0]        upleft_px [MAX_PIX];
    ptru_pkg::pos_t    col;
    ptru_pkg::filter_e filt;
    logic              drop;
    pixel_out_t        expected_q [$];
    int                errors;

    function new();
      mode    = ptru_pkg::MODE_PNG;
      bpp_reg = 4'd1;
      row_reg = 13'd1;
      foreach (prior_line[i]) prior_line[i] = 8'h00;
      foreach (left_px[i]) begin
        left_px[i]   = 8'h00;
        upleft_px[i] = 8'h00;
      end
      col    = '0;
      filt   = ptru_pkg::FILT_NONE;
      drop   = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, cfg_data_t val);
      case (idx)
        ptru_pkg::REG_MODE: mode = val[0];
        ptru_pkg::REG_BPP:  bpp_reg = val[ptru_pkg::BPP_W-1:0];
        ptru_pkg::REG_ROW:  row_reg = val[ptru_pkg::POS_W-1:0];
        default: ;
      endcase
    endfunction

    function int clamp(int v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int paeth_pick(int a, int b, int c);
      int pa;
      int pb;
      int pc;
      pa = (b > c) ? b - c : c - b;
      pb = (a > c) ? a - c : c - a;
      pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
    endfunction

    function void push_result(logic [7:0] px, logic re, logic bad);
      pixel_out_t res;
      res.pixel   = px;
      res.row_end = re;
      res.bad     = bad;
      expected_q.push_back(res);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [7:0] d);
      int         bpp;
      int         rb;
      int         p;
      int         slot;
      int         a;
      int         b;
      int         c;
      int         pred;
      int         sum;
      logic       last;
      logic [7:0] r;
      logic [7:0] f;
      bpp = clamp(int'(bpp_reg), MAX_PIX);
      rb  = clamp(int'(row_reg), MAX_ROW);
      if (mode == ptru_pkg::MODE_TIFF) begin
        p    = int'(col);
        slot = p % bpp;
        a    = (p >= bpp) ? int'(left_px[slot]) : 0;
        sum  = int'(d) + a;
        r    = sum[7:0];
        left_px[slot] = r;
        last = (p + 1 >= rb);
        col  = last ? '0 : ptru_pkg::pos_t'(p + 1);
        push_result(r, last, 1'b0);
        return;
      end
      if (col == '0) begin
        col = 13'd1;
        if (d <= ptru_pkg::FILTER_CODE_MAX ||
            (d >= ptru_pkg::FILTER_ALIAS_BASE && d <= ptru_pkg::FILTER_ALIAS_MAX)) begin
          f    = (d >= ptru_pkg::FILTER_ALIAS_BASE) ? d - ptru_pkg::FILTER_ALIAS_BASE : d;
          filt = ptru_pkg::filter_e'(f[2:0]);
          drop = 1'b0;
        end else begin
          filt = ptru_pkg::FILT_NONE;
          drop = 1'b1;
          push_result(8'h00, 1'b0, 1'b1);
        end
        return;
      end
      p    = int'(col) - 1;
      last = (p + 1 >= rb);
      col  = last ? '0 : col + 1'b1;
      if (drop) begin
        if (last) drop = 1'b0;
        return;
      end
      slot = p % bpp;
      b    = (p < MAX_ROW) ? int'(prior_line[p]) : 0;
      a    = (p >= bpp) ? int'(left_px[slot]) : 0;
      c    = (p >= bpp) ? int'(upleft_px[slot]) : 0;
      case (filt)
        ptru_pkg::FILT_SUB:   pred = a;
        ptru_pkg::FILT_UP:    pred = b;
        ptru_pkg::FILT_AVG:   pred = (a + b) >> 1;
        ptru_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
        default:              pred = 0;
      endcase
      sum = int'(d) + pred;
      r   = sum[7:0];
      upleft_px[slot] = 8'(b);
      left_px[slot]   = r;
      if (p < MAX_ROW) prior_line[p] = r;
      push_result(r, last, 1'b0);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) begin
        $display("%0t ns: mismatch: %s", $time, msg);
      end
    endtask

    task check_result(logic [7:0] px, logic re, logic bad);
      pixel_out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result pixel=%02h row_end=%0b bad_filter=%0b",
                         px, re, bad));
        return;
      end
      want = expected_q.pop_front();
      if (px !== want.pixel) begin
        report($sformatf("pixel_byte %02h, expected %02h", px, want.pixel));
      end
      if (re !== want.row_end) begin
        report($sformatf("row_end %0b, expected %0b", re, want.row_end));
      end
      if (bad !== want.bad) begin
        report($sformatf("bad_filter %0b, expected %0b", bad, want.bad));
      end
    endtask
  endclass

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [7:0] data_byte_i  = 8'h00;
  logic       out_ready_i  = 1'b0;
  logic       cfg_we_i     = 1'b0;
  cfg_idx_t   cfg_index_i  = ptru_pkg::REG_MODE;
  cfg_data_t  cfg_wdata_i  = '0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] pixel_byte_o;
  logic       row_end_o;
  logic       bad_filter_o;

  unfilter_scoreboard sb;
  int burst_left = 0;
  int ready_tick = 0;
  int hold_cnt   = 0;
  int cycle_count = 0;

  png_tiff_row_unfilter_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_byte_o (pixel_byte_o),
    .row_end_o    (row_end_o),
    .bad_filter_o (bad_filter_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    case ((ready_tick / 256) % 4)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      2: out_ready_i <= (ready_tick % 4 == 0);
      default: begin
        if (hold_cnt == 0) begin
          out_ready_i <= ~out_ready_i;
          hold_cnt    <= $urandom_range(1, 12);
        end else begin
          hold_cnt <= hold_cnt - 1;
        end
      end
    endcase
    ready_tick <= ready_tick + 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(pixel_byte_o, row_end_o, bad_filter_o);
    end
  end

  task automatic send_byte(input logic [7:0] d);
    int gap;
    bit hold_for_drain;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    hold_for_drain = ($urandom_range(0, 149) == 0);
    if (gap > 0 || hold_for_drain) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (hold_for_drain) begin
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(d);
  endtask

  function automatic logic [7:0] pick_byte();
    int roll;
    logic [7:0] code;
    if (sb.mode == ptru_pkg::MODE_PNG && sb.col == '0) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        code = 8'($urandom_range(0, ptru_pkg::FILTER_CODE_MAX));
        if ($urandom_range(0, 1) == 1) code = code + ptru_pkg::FILTER_ALIAS_BASE;
        return code;
      end else if (roll < 90) begin
        return 8'($urandom_range(ptru_pkg::FILTER_CODE_MAX + 1,
                                 ptru_pkg::FILTER_ALIAS_BASE - 1));
      end else begin
        return 8'($urandom_range(0, 255));
      end
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic run_phase(input logic mode, input ptru_pkg::bpp_t bpp,
                           input ptru_pkg::pos_t rows, input int n);
    cfg_data_t junk;
    junk = cfg_data_t'($urandom);
    if ($urandom_range(0, 1) == 0) junk = '0;
    wait_idle();
    write_reg(ptru_pkg::REG_MODE, {junk[ptru_pkg::CFG_DATA_W-1:1], mode});
    write_reg(ptru_pkg::REG_BPP, {junk[ptru_pkg::CFG_DATA_W-1:ptru_pkg::BPP_W], bpp});
    write_reg(ptru_pkg::REG_ROW, rows);
    cfg_we_i <= 1'b0;
    repeat (n) send_byte(pick_byte());
    in_valid_i <= 1'b0;
  endtask

  initial begin
    int             random_items;
    int             n;
    int             roll;
    ptru_pkg::pos_t rows;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one-byte PNG rows, every filter code and its alias,
    // then two unknown filter codes whose data byte must be swallowed.
    for (int i = 0; i < 10; i++) begin
      send_byte(8'((i <= int'(ptru_pkg::FILTER_CODE_MAX)) ? i :
                   int'(ptru_pkg::FILTER_ALIAS_BASE) + i -
                   int'(ptru_pkg::FILTER_CODE_MAX) - 1));
      send_byte(i[0] ? 8'h00 : 8'hFF);
    end
    send_byte(ptru_pkg::FILTER_CODE_MAX + 8'd1);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h7F);
    in_valid_i <= 1'b0;

    run_phase(ptru_pkg::MODE_PNG, 4'd3, 13'd12, 60);
    run_phase(ptru_pkg::MODE_PNG, 4'd0, 13'd7, 40);
    run_phase(ptru_pkg::MODE_TIFF, 4'd15, 13'd20, 50);
    run_phase(ptru_pkg::MODE_PNG, 4'd8, 13'd16, 60);
    run_phase(ptru_pkg::MODE_TIFF, 4'd1, 13'd0, 30);
    run_phase(ptru_pkg::MODE_PNG, 4'd1, 13'd0, 30);
    run_phase(ptru_pkg::MODE_PNG, 4'd2, 13'd4096, 60);
    run_phase(ptru_pkg::MODE_TIFF, 4'd8, 13'd8191, 60);
    run_phase(ptru_pkg::MODE_PNG, 4'd15, 13'd8191, 40);

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) rows = ptru_pkg::pos_t'($urandom_range(0, 24));
      else if (roll < 95) rows = ptru_pkg::pos_t'($urandom_range(25, 200));
      else rows = ptru_pkg::pos_t'($urandom_range(4097, 8191));
      n = $urandom_range(20, 80);
      run_phase(1'($urandom_range(0, 1)), ptru_pkg::bpp_t'($urandom_range(0, 15)),
                rows, n);
      random_items += n;
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
